### rtl/md5_pkg.sv
// md5_pkg: request and response types, round constants and helper functions for the md5 engine
// no dependencies
package md5_pkg;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        last;
	} md5_in_t;

	typedef struct packed {
		logic [31:0] digest_a;
		logic [31:0] digest_b;
		logic [31:0] digest_c;
		logic [31:0] digest_d;
	} md5_out_t;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [31:0] PAD_BYTE = 32'h00000080;

	localparam logic [31:0] STEP_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// message word index used by a step
	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [3:0] lo;
		lo = i[3:0];
		unique case (i[5:4])
			2'd0: msg_index = lo;
			2'd1: msg_index = 4'((lo << 2) + lo + 4'd1);
			2'd2: msg_index = 4'((lo << 1) + lo + 4'd5);
			default: msg_index = 4'((lo << 3) - lo);
		endcase
	endfunction

	function automatic logic [4:0] rot_amt(input logic [5:0] i);
		logic [4:0] r;
		unique case ({i[5:4], i[1:0]})
			4'h0: r = 5'd7;  4'h1: r = 5'd12; 4'h2: r = 5'd17; 4'h3: r = 5'd22;
			4'h4: r = 5'd5;  4'h5: r = 5'd9;  4'h6: r = 5'd14; 4'h7: r = 5'd20;
			4'h8: r = 5'd4;  4'h9: r = 5'd11; 4'ha: r = 5'd16; 4'hb: r = 5'd23;
			4'hc: r = 5'd6;  4'hd: r = 5'd10; 4'he: r = 5'd15; default: r = 5'd21;
		endcase
		rot_amt = r;
	endfunction

endpackage

### rtl/md5_digest_engine_unit.sv
// md5_digest_engine_unit: top level of the md5 engine, sequencer and chaining state
// depends on md5_pkg, md5_block_ram, md5_step_unit
//
//  channel | dir | payload            | handshake
//  req     | in  | md5_pkg::md5_in_t  | req_valid / req_ready
//  rsp     | out | md5_pkg::md5_out_t | rsp_valid / rsp_ready
//
// a non-last request that completes a block starts a compression of 64 steps
// (each a buffer read, a step and a write-back), then a chain add.
// a last request writes pad words one per cycle and compresses one or two
// blocks, each step a registered buffer read, a registered step and a write-back.
// reset restores the md5 initial chaining words and clears the fill and length.
// a finished digest waits in the output register; non-last requests are taken
// meanwhile, a last request waits until the digest leaves.
module md5_digest_engine_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  md5_pkg::md5_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output md5_pkg::md5_out_t rsp
);
	import md5_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_RD, ST_STEP, ST_WB, ST_ADD
	} state_t;

	state_t      state_q;
	logic [3:0]  fill_q;
	logic [63:0] len_q;
	logic [31:0] ca_q, cb_q, cc_q, cd_q;
	logic [31:0] wa_q, wb_q, wc_q, wd_q;
	logic [5:0]  step_q;
	logic        fin_q;   // message finishing
	logic        lenw_q;  // length words are being written
	logic [31:0] tail_q;  // first pad word

	logic        we;
	logic [3:0]  waddr;
	logic [31:0] wdata, rdata, b_next;
	logic [2:0]  cnt;
	logic [31:0] mask, padw;
	logic [63:0] len_fin;

	md5_block_ram u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(msg_index(step_q)), .rdata(rdata)
	);

	md5_step_unit u_step (
		.clk(clk), .step(step_q), .a(wa_q), .b(wb_q), .c(wc_q), .d(wd_q),
		.m(rdata), .b_next(b_next)
	);

	// last-word padding
	always_comb begin
		cnt = (req.byte_count > 3'd4) ? 3'd4 : req.byte_count;
		unique case (cnt)
			3'd0: mask = 32'h0;
			3'd1: mask = 32'h000000ff;
			3'd2: mask = 32'h0000ffff;
			3'd3: mask = 32'h00ffffff;
			default: mask = 32'hffffffff;
		endcase
		padw    = (req.data_word & mask) | (PAD_BYTE << {cnt[1:0], 3'b000});
		len_fin = len_q + {58'd0, cnt, 3'b000};
	end

	assign req_ready = (state_q == ST_IDLE) && !(rsp_valid && !rsp_ready && req.last);

	// buffer write selection
	always_comb begin
		we = 1'b0;
		waddr = fill_q;
		wdata = req.data_word;
		if (state_q == ST_IDLE && req_valid && req_ready) begin
			we = 1'b1;
			if (req.last && cnt != 3'd4) wdata = padw;
		end else if (state_q == ST_PAD) begin
			we = 1'b1;
			if (tail_q != 32'h0) wdata = tail_q;
			else if (lenw_q && fill_q == 4'd14) wdata = len_q[31:0];
			else if (lenw_q && fill_q == 4'd15) wdata = len_q[63:32];
			else wdata = 32'h0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= 4'd0; len_q <= 64'd0; step_q <= 6'd0;
			ca_q <= INIT_A; cb_q <= INIT_B; cc_q <= INIT_C; cd_q <= INIT_D;
			wa_q <= 32'd0; wb_q <= 32'd0; wc_q <= 32'd0; wd_q <= 32'd0;
			fin_q <= 1'b0; lenw_q <= 1'b0; tail_q <= 32'd0;
			rsp_valid <= 1'b0; rsp <= '0;
		end else begin
			if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid && req_ready) begin
						if (!req.last) begin
							len_q <= len_q + 64'd32;
							fill_q <= fill_q + 4'd1;
							if (fill_q == 4'd15) begin
								state_q <= ST_RD;
								wa_q <= ca_q; wb_q <= cb_q; wc_q <= cc_q; wd_q <= cd_q;
							end
						end else begin
							len_q <= len_fin;
							fin_q <= 1'b1;
							if (cnt == 3'd4) begin
								tail_q <= PAD_BYTE;
								lenw_q <= 1'b0;
								fill_q <= fill_q + 4'd1;
								if (fill_q == 4'd15) begin
									state_q <= ST_RD;
									wa_q <= ca_q; wb_q <= cb_q; wc_q <= cc_q; wd_q <= cd_q;
								end else state_q <= ST_PAD;
							end else begin
								tail_q <= 32'd0;
								lenw_q <= (fill_q < 4'd14);
								fill_q <= fill_q + 4'd1;
								if (fill_q == 4'd15) begin
									state_q <= ST_RD;
									wa_q <= ca_q; wb_q <= cb_q; wc_q <= cc_q; wd_q <= cd_q;
								end else state_q <= ST_PAD;
							end
						end
					end
				end
				ST_PAD: begin
					// one pad word per cycle until the block is full
					if (tail_q != 32'h0) begin
						tail_q <= 32'd0;
						lenw_q <= (fill_q < 4'd14);
					end
					fill_q <= fill_q + 4'd1;
					if (fill_q == 4'd15) begin
						state_q <= ST_RD;
						wa_q <= ca_q; wb_q <= cb_q; wc_q <= cc_q; wd_q <= cd_q;
					end
				end
				ST_RD:   state_q <= ST_STEP;
				ST_STEP: state_q <= ST_WB;
				ST_WB: begin
					wa_q <= wd_q; wd_q <= wc_q; wc_q <= wb_q; wb_q <= b_next;
					step_q <= step_q + 6'd1;
					state_q <= (step_q == 6'd63) ? ST_ADD : ST_RD;
				end
				ST_ADD: begin
					if (fin_q && lenw_q) begin
						// digest out, back to reset state
						rsp_valid <= 1'b1;
						rsp.digest_a <= ca_q + wa_q; rsp.digest_b <= cb_q + wb_q;
						rsp.digest_c <= cc_q + wc_q; rsp.digest_d <= cd_q + wd_q;
						ca_q <= INIT_A; cb_q <= INIT_B; cc_q <= INIT_C; cd_q <= INIT_D;
						len_q <= 64'd0; fin_q <= 1'b0; lenw_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						ca_q <= ca_q + wa_q; cb_q <= cb_q + wb_q;
						cc_q <= cc_q + wc_q; cd_q <= cd_q + wd_q;
						if (fin_q) begin
							// second final block
							if (tail_q == 32'h0) lenw_q <= 1'b1;
							state_q <= ST_PAD;
						end else state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// a new digest never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("pending digest lost");
	// steps advance only on write-back
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_WB |=> $stable(step_q))
		else $error("step index moved outside write-back");
	// buffer is never written while a block compresses
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_STEP || state_q == ST_WB) |-> !we)
		else $error("block buffer written during compression");
`endif
endmodule

### rtl/md5_block_ram.sv
// md5_block_ram: sixteen-word block buffer, one write and one registered read port
// no dependencies
module md5_block_ram (
	input  logic        clk,
	input  logic        we,
	input  logic [3:0]  waddr,
	input  logic [31:0] wdata,
	input  logic [3:0]  raddr,
	output logic [31:0] rdata
);
	logic [31:0] mem [16];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

### rtl/md5_step_unit.sv
// md5_step_unit: one md5 step on the working words, registered result
// depends on md5_pkg for step constants and rotation table
module md5_step_unit (
	input  logic        clk,
	input  logic [5:0]  step,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	input  logic [31:0] d,
	input  logic [31:0] m,
	output logic [31:0] b_next
);
	import md5_pkg::*;
	logic [31:0] f, sum;
	logic [4:0]  s;
	logic [63:0] dbl;

	// round function and step sum
	always_comb begin
		unique case (step[5:4])
			2'd0: f = (b & c) | (~b & d);
			2'd1: f = (b & d) | (c & ~d);
			2'd2: f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		sum = a + f + STEP_K[step] + m;
		s   = rot_amt(step);
		dbl = {sum, sum} << s;
	end

	always_ff @(posedge clk) begin
		b_next <= b + dbl[63:32];
	end
endmodule

### tb/md5_digest_engine_unit_tb.sv
// md5_digest_engine_unit_tb: checks md5 digests of random and directed messages
// against an in-bench md5 model; depends on md5_pkg and md5_digest_engine_unit
`timescale 1ns / 1ps

module md5_digest_engine_unit_tb;
	import md5_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	md5_in_t  req;
	logic     rsp_valid;
	logic     rsp_ready;
	md5_out_t rsp;

	md5_digest_engine_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// idling phases of the random run: none, sender, receiver, both
	localparam int PHASE_NONE = 0;
	localparam int PHASE_SEND = 1;
	localparam int PHASE_RECV = 2;
	localparam int PHASE_BOTH = 3;

	md5_in_t  pending_reqs[$];
	md5_out_t expected_digests[$];
	int       mismatches = 0;
	int       digests_seen = 0;
	int       reqs_sent = 0;
	int       idle_pct_send = 0;
	int       idle_pct_recv = 0;
	bit       stim_done = 0;
	bit       req_taken = 0;

	// digest model state
	logic [31:0] chain_q[4];
	logic [31:0] blk_q[16];
	int          fill_q;
	logic [63:0] msg_bits_q;

	localparam logic [31:0] K_TAB[64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int SHIFT_TAB[16] = '{7, 12, 17, 22, 5, 9, 14, 20,
		4, 11, 16, 23, 6, 10, 15, 21};

	task automatic md5_clear();
		chain_q[0] = 32'h67452301;
		chain_q[1] = 32'hefcdab89;
		chain_q[2] = 32'h98badcfe;
		chain_q[3] = 32'h10325476;
		fill_q = 0;
		msg_bits_q = '0;
	endtask

	// 64 steps over the buffered block, then chain add
	task automatic md5_compress();
		logic [31:0] a, b, c, d, f, t;
		int g, rnd;
		a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
		for (int i = 0; i < 64; i++) begin
			rnd = i / 16;
			case (rnd)
				0: begin f = (b & c) | (~b & d); g = i; end
				1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
				2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
				default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
			endcase
			f = a + f + K_TAB[i] + blk_q[g];
			t = (f << SHIFT_TAB[rnd * 4 + i % 4]) | (f >> (32 - SHIFT_TAB[rnd * 4 + i % 4]));
			a = d; d = c; c = b; b = b + t;
		end
		chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
	endtask

	task automatic md5_push(input logic [31:0] w);
		blk_q[fill_q] = w;
		fill_q = (fill_q + 1) % 16;
		if (fill_q == 0)
			md5_compress();
	endtask

	// absorb one request, queue a digest on a last request
	task automatic md5_absorb(input md5_in_t r);
		int cnt;
		logic [31:0] pad;
		md5_out_t dg;
		cnt = (r.byte_count > 4) ? 4 : r.byte_count;
		if (!r.last) begin
			msg_bits_q += 32;
			md5_push(r.data_word);
		end else begin
			msg_bits_q += cnt * 8;
			if (cnt == 4) begin
				md5_push(r.data_word);
				pad = PAD_BYTE;
			end else begin
				pad = (cnt == 0) ? 32'h0 : (r.data_word & (32'hffffffff >> (32 - 8 * cnt)));
				pad |= PAD_BYTE << (8 * cnt);
			end
			md5_push(pad);
			if (fill_q > 14)
				while (fill_q != 0) md5_push(32'h0);
			while (fill_q < 14) md5_push(32'h0);
			md5_push(msg_bits_q[31:0]);
			md5_push(msg_bits_q[63:32]);
			dg.digest_a = chain_q[0]; dg.digest_b = chain_q[1];
			dg.digest_c = chain_q[2]; dg.digest_d = chain_q[3];
			expected_digests.push_back(dg);
			md5_clear();
		end
	endtask

	function automatic md5_in_t make_req(logic [31:0] w, logic [2:0] n, logic l);
		md5_in_t r;
		r.data_word = w; r.byte_count = n; r.last = l;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		mismatches++;
	endtask

	// clock
	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	// driver: present pending requests at falling edges
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_valid && req_taken) begin
				// accepted at the last rising edge
				if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct_send) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else
					req_valid <= 1'b0;
			end else if (!req_valid && pending_reqs.size() != 0
					&& $urandom_range(99) >= idle_pct_send) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
			end
			rsp_ready <= ($urandom_range(99) >= idle_pct_recv);
		end
	end

	// monitor: predict on accepted requests, compare accepted digests
	always @(posedge clk) begin
		md5_out_t want;
		req_taken <= arst_n && req_valid && req_ready;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				md5_absorb(req);
				reqs_sent++;
			end
			if (rsp_valid && rsp_ready) begin
				digests_seen++;
				if (expected_digests.size() == 0) begin
					report_mismatch("unexpected digest a", rsp.digest_a, 32'h0);
				end else begin
					want = expected_digests.pop_front();
					if (rsp.digest_a !== want.digest_a) report_mismatch("a", rsp.digest_a, want.digest_a);
					if (rsp.digest_b !== want.digest_b) report_mismatch("b", rsp.digest_b, want.digest_b);
					if (rsp.digest_c !== want.digest_c) report_mismatch("c", rsp.digest_c, want.digest_c);
					if (rsp.digest_d !== want.digest_d) report_mismatch("d", rsp.digest_d, want.digest_d);
				end
			end
		end
	end

	// queue one message of nwords full words plus a random tail
	task automatic queue_message(input int nwords);
		for (int i = 0; i < nwords; i++)
			pending_reqs.push_back(make_req($urandom, 3'd4, 1'b0));
		pending_reqs.push_back(make_req($urandom, 3'($urandom_range(7)), 1'b1));
	endtask

	task automatic drain_all();
		while (pending_reqs.size() != 0 || req_valid || expected_digests.size() != 0)
			@(posedge clk);
	endtask

	// stimulus
	initial begin
		int remaining, n;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		md5_clear();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty message, partial tails, oversize counts, short words mid-message
		pending_reqs.push_back(make_req(32'hffffffff, 3'd0, 1'b1));
		pending_reqs.push_back(make_req(32'hffffffff, 3'd1, 1'b1));
		pending_reqs.push_back(make_req(32'h00636261, 3'd3, 1'b1));
		pending_reqs.push_back(make_req(32'hffffffff, 3'd4, 1'b1));
		pending_reqs.push_back(make_req(32'h00000000, 3'd7, 1'b1));
		pending_reqs.push_back(make_req(32'hdeadbeef, 3'd2, 1'b0));
		pending_reqs.push_back(make_req(32'h12345678, 3'd5, 1'b0));
		pending_reqs.push_back(make_req(32'hffffffff, 3'd6, 1'b1));
		// 13 and 14 full words: only the 14-word message spills its padding into a second block
		for (int i = 0; i < 13; i++) pending_reqs.push_back(make_req(32'haaaaaaaa, 3'd4, 1'b0));
		pending_reqs.push_back(make_req(32'h55555555, 3'd3, 1'b1));
		for (int i = 0; i < 14; i++) pending_reqs.push_back(make_req(32'h0, 3'd4, 1'b0));
		pending_reqs.push_back(make_req(32'hffffffff, 3'd0, 1'b1));
		drain_all();

		// random messages across the idling phases
		remaining = 1250;
		for (int ph = PHASE_NONE; ph <= PHASE_BOTH; ph++) begin
			idle_pct_send = (ph == PHASE_SEND) ? 50 : (ph == PHASE_BOTH) ? 34 : 0;
			idle_pct_recv = (ph == PHASE_RECV) ? 50 : (ph == PHASE_BOTH) ? 34 : 0;
			for (int k = 0; k < remaining / (4 - ph) && k < 1250; ) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(17);
				queue_message(n);
				k += n + 1;
				remaining -= n + 1;
			end
			drain_all();
		end
		idle_pct_send = 0;
		idle_pct_recv = 0;
		repeat (500) @(posedge clk);

		$display("sent %0d requests, checked %0d digests across four idling phases",
			reqs_sent, digests_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog
	initial begin
		#60ms;
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end

endmodule
